// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, held off while reset is asserted
`define CSPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Clocked check that also holds during reset
`define CSPI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define CSPI_ASSERT(lbl, prop, msg)
`define CSPI_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/cspi_pkg.sv =====
package cspi_pkg;

  // Loop constants
  localparam int SCHED_SHIFT   = 8;
  localparam int SPEED_SHIFT   = 12;
  localparam int CURRENT_SHIFT = 12;
  localparam int SPEED_DIVIDE  = 10;
  localparam int CURRENT_LIMIT = 4096;
  localparam int DRIVE_MAX     = 32767;

  localparam logic [15:0]        SPD_DIV     = 16'(SPEED_DIVIDE);
  localparam logic signed [15:0] CUR_LIM_POS = 16'(CURRENT_LIMIT);
  localparam logic signed [15:0] CUR_LIM_NEG = 16'(-CURRENT_LIMIT);

  // Scheduled kp: (diff * slope >> SCHED_SHIFT) + kp_high, kept to KP_W = 25 bits (capped at 32)
  localparam int KP_RAW = ((32 - SCHED_SHIFT) > 15 ? (32 - SCHED_SHIFT) : 15) + 1;
  localparam int KP_W   = (KP_RAW > 32) ? 32 : KP_RAW;
  // Shared multiplier: signed 18-bit A, signed B holding unsigned kp or gains
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = KP_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [KP_W-1:0]    kp_t;
  typedef logic [31:0]        word_t;
  typedef logic [MUL_B_W-1:0] mulb_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_SHELF = 3'd0,
    CFG_LOW_SHELF  = 3'd1,
    CFG_SKP_HIGH   = 3'd2,
    CFG_SKP_LOW    = 3'd3,
    CFG_SLOPE      = 3'd4,
    CFG_SPEED_KI   = 3'd5,
    CFG_CUR_KP     = 3'd6,
    CFG_CUR_KI     = 3'd7
  } cfg_reg_e;

  // Operand pair on the shared multiplier
  typedef enum logic [2:0] {
    MUL_SCHED = 3'd0,
    MUL_SKI   = 3'd1,
    MUL_SKP   = 3'd2,
    MUL_CKI   = 3'd3,
    MUL_CKP   = 3'd4
  } mul_op_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    latch;
    logic    check;
    logic    sched;
    logic    spd_int;
    logic    spd_out;
    logic    cur_int;
    logic    cur_out;
    logic    out_load;
    mul_op_e mul_op;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear;
    logic speed_run;
  } sts_t;

endpackage

// ===== hw/rtl/cspi_ctrl.sv =====
`include "assert_macros.svh"

module cspi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  cspi_pkg::sts_t sts_i,
  output cspi_pkg::cmd_t cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_CHECK = 10'b00_0000_0010,
    S_SCHED = 10'b00_0000_0100,
    S_SKP   = 10'b00_0000_1000,
    S_SI    = 10'b00_0001_0000,
    S_SOUT  = 10'b00_0010_0000,
    S_CKI   = 10'b00_0100_0000,
    S_CI    = 10'b00_1000_0000,
    S_COUT  = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequencer: one multiplier product per step
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.mul_op   = cspi_pkg::MUL_CKP;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.clear) begin
          state_d = S_OUT;
        end else if (sts_i.speed_run) begin
          state_d = S_SCHED;
        end else begin
          state_d = S_CKI;
        end
      end
      S_SCHED: begin
        cmd_o.mul_op = cspi_pkg::MUL_SCHED;
        state_d      = S_SKP;
      end
      S_SKP: begin
        cmd_o.sched  = 1'b1;
        cmd_o.mul_op = cspi_pkg::MUL_SKI;
        state_d      = S_SI;
      end
      S_SI: begin
        cmd_o.spd_int = 1'b1;
        cmd_o.mul_op  = cspi_pkg::MUL_SKP;
        state_d       = S_SOUT;
      end
      S_SOUT: begin
        cmd_o.spd_out = 1'b1;
        state_d       = S_CKI;
      end
      S_CKI: begin
        cmd_o.mul_op = cspi_pkg::MUL_CKI;
        state_d      = S_CI;
      end
      S_CI: begin
        cmd_o.cur_int = 1'b1;
        cmd_o.mul_op  = cspi_pkg::MUL_CKP;
        state_d       = S_COUT;
      end
      S_COUT: begin
        cmd_o.cur_out = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        // post the result once the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid: set on load, cleared on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `CSPI_ASSERT(a_accept_starts_tick, (in_valid_i && in_ready_o) |=> (state_q == S_CHECK), "accepted tick did not start")
  `CSPI_ASSERT(a_result_waits, (state_q == S_OUT && out_valid_q && !out_ready_i) |=> (state_q == S_OUT && out_valid_q), "result overwrote a pending one")
  `CSPI_ASSERT_ALWAYS(a_no_accept_on_post, !(in_ready_o && cmd_o.out_load), "accept while posting result")

endmodule

// ===== hw/rtl/cspi_dp.sv =====
`include "assert_macros.svh"

module cspi_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cspi_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cspi_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic signed [15:0]                target_rpm_i,
  input  logic signed [15:0]                measured_rpm_i,
  input  logic signed [15:0]                measured_current_i,
  input  logic                              clear_i,
  input  cspi_pkg::cmd_t                    cmd_i,
  output cspi_pkg::sts_t                    sts_o,
  output logic signed [15:0]                current_ref_o,
  output logic [14:0]                       drive_o,
  output logic                              speed_clamped_o,
  output logic                              drive_clamped_o,
  output logic                              speed_updated_o
);

  // Configuration registers
  logic signed [15:0] high_q, low_q;
  logic [14:0]        skp_high_q, skp_low_q, ski_q, ckp_q, cki_q;
  logic [15:0]        slope_q;

  // Latched tick inputs
  logic signed [15:0] tgt_q, mrpm_q, mcur_q;
  logic               clr_q;

  // Loop state
  logic [31:0]        spd_int_q, spd_int_d;
  logic [31:0]        cur_int_q, cur_int_d;
  logic signed [15:0] spd_out_q, spd_out_d;
  logic               spd_unsat_q, spd_unsat_d;
  logic               cur_unsat_q, cur_unsat_d;
  logic [15:0]        cnt_q, cnt_d;
  logic [14:0]        drive_q, drive_d;
  logic               sclamp_q, sclamp_d;
  logic               dclamp_q, dclamp_d;
  logic               supd_q, supd_d;

  // Multiplier and scheduled gain
  cspi_pkg::kp_t      kp_q;
  logic [31:0]        prod_q;
  logic signed [cspi_pkg::MUL_A_W-1:0] mul_a;
  logic signed [cspi_pkg::MUL_B_W-1:0] mul_b;
  logic signed [cspi_pkg::MUL_P_W-1:0] mul_p;

  logic signed [16:0] spd_err, cur_err, sched_diff;
  logic [15:0]        cnt_inc;
  cspi_pkg::kp_t      kp_sched;
  logic [31:0]        spd_sum, cur_sum, cur_base;
  logic signed [31:0] spd_shift, cur_shift;
  logic signed [15:0] spd_sig;

  // Differences, all 17-bit signed
  assign spd_err    = {tgt_q[15], tgt_q} - {mrpm_q[15], mrpm_q};
  assign cur_err    = {spd_out_q[15], spd_out_q} - {mcur_q[15], mcur_q};
  assign sched_diff = {high_q[15], high_q} - {tgt_q[15], tgt_q};

  assign cnt_inc = cnt_q + 16'd1;

  assign sts_o.clear     = clr_q;
  assign sts_o.speed_run = (cnt_inc >= cspi_pkg::SPD_DIV);

  // Shared multiplier operand select
  always_comb begin
    unique case (cmd_i.mul_op)
      cspi_pkg::MUL_SCHED: begin
        mul_a = {sched_diff[16], sched_diff};
        mul_b = cspi_pkg::mulb_t'(slope_q);
      end
      cspi_pkg::MUL_SKI: begin
        mul_a = {spd_err[16], spd_err};
        mul_b = cspi_pkg::mulb_t'(ski_q);
      end
      cspi_pkg::MUL_SKP: begin
        mul_a = {spd_err[16], spd_err};
        mul_b = cspi_pkg::mulb_t'(kp_q);
      end
      cspi_pkg::MUL_CKI: begin
        mul_a = {cur_err[16], cur_err};
        mul_b = cspi_pkg::mulb_t'(cki_q);
      end
      cspi_pkg::MUL_CKP: begin
        mul_a = {cur_err[16], cur_err};
        mul_b = cspi_pkg::mulb_t'(ckp_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Gain schedule between the shelves
  always_comb begin
    if (tgt_q > high_q) begin
      kp_sched = cspi_pkg::kp_t'(skp_high_q);
    end else if (tgt_q > low_q) begin
      kp_sched = cspi_pkg::kp_t'(prod_q[31:cspi_pkg::SCHED_SHIFT])
               + cspi_pkg::kp_t'(skp_high_q);
    end else begin
      kp_sched = cspi_pkg::kp_t'(skp_low_q);
    end
  end

  // Loop sums and arithmetic shifts
  assign spd_sum   = prod_q + spd_int_q;
  assign spd_shift = $signed(spd_sum) >>> cspi_pkg::SPEED_SHIFT;
  assign spd_sig   = spd_shift[15:0];
  assign cur_sum   = prod_q + cur_int_q;
  assign cur_shift = $signed(cur_sum) >>> cspi_pkg::CURRENT_SHIFT;
  assign cur_base  = (tgt_q == '0) ? '0 : cur_int_q;

  // Loop state updates per step
  always_comb begin
    spd_int_d   = spd_int_q;
    cur_int_d   = cur_int_q;
    spd_out_d   = spd_out_q;
    spd_unsat_d = spd_unsat_q;
    cur_unsat_d = cur_unsat_q;
    cnt_d       = cnt_q;
    drive_d     = drive_q;
    sclamp_d    = sclamp_q;
    dclamp_d    = dclamp_q;
    supd_d      = supd_q;

    if (cmd_i.check) begin
      sclamp_d = 1'b0;
      if (clr_q) begin
        spd_int_d = '0;
        cur_int_d = '0;
        spd_out_d = '0;
        cnt_d     = '0;
        drive_d   = '0;
        dclamp_d  = 1'b0;
        supd_d    = 1'b0;
      end else begin
        cnt_d  = sts_o.speed_run ? '0 : cnt_inc;
        supd_d = sts_o.speed_run;
      end
    end

    if (cmd_i.spd_int && spd_unsat_q) begin
      spd_int_d = spd_int_q + prod_q;
    end

    // speed output: clamp to the current limit
    if (cmd_i.spd_out) begin
      if (spd_sig > cspi_pkg::CUR_LIM_POS) begin
        spd_out_d   = cspi_pkg::CUR_LIM_POS;
        spd_unsat_d = 1'b0;
        sclamp_d    = 1'b1;
      end else if (spd_sig < cspi_pkg::CUR_LIM_NEG) begin
        spd_out_d   = cspi_pkg::CUR_LIM_NEG;
        spd_unsat_d = 1'b0;
        sclamp_d    = 1'b1;
      end else begin
        spd_out_d   = spd_sig;
        spd_unsat_d = 1'b1;
      end
    end

    // zero target drops the current integral first
    if (cmd_i.cur_int) begin
      cur_int_d = cur_unsat_q ? (cur_base + prod_q) : cur_base;
    end

    // drive: clamp to 0..DRIVE_MAX
    if (cmd_i.cur_out) begin
      if (cur_shift > cspi_pkg::DRIVE_MAX) begin
        drive_d     = 15'(cspi_pkg::DRIVE_MAX);
        cur_unsat_d = 1'b0;
        dclamp_d    = 1'b1;
      end else if (cur_shift[31]) begin
        drive_d     = '0;
        cur_unsat_d = 1'b0;
        dclamp_d    = 1'b1;
      end else begin
        drive_d     = cur_shift[14:0];
        cur_unsat_d = 1'b1;
        dclamp_d    = 1'b0;
      end
    end
  end

  // Control state, configuration and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q      <= '0;
      low_q       <= '0;
      skp_high_q  <= '0;
      skp_low_q   <= '0;
      slope_q     <= '0;
      ski_q       <= '0;
      ckp_q       <= '0;
      cki_q       <= '0;
      spd_int_q   <= '0;
      cur_int_q   <= '0;
      spd_out_q   <= '0;
      spd_unsat_q <= 1'b0;
      cur_unsat_q <= 1'b0;
      cnt_q       <= '0;
      drive_q     <= '0;
      sclamp_q    <= 1'b0;
      dclamp_q    <= 1'b0;
      supd_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cspi_pkg::cfg_reg_e'(cfg_idx_i))
          cspi_pkg::CFG_HIGH_SHELF: high_q     <= cfg_data_i;
          cspi_pkg::CFG_LOW_SHELF:  low_q      <= cfg_data_i;
          cspi_pkg::CFG_SKP_HIGH:   skp_high_q <= cfg_data_i[14:0];
          cspi_pkg::CFG_SKP_LOW:    skp_low_q  <= cfg_data_i[14:0];
          cspi_pkg::CFG_SLOPE:      slope_q    <= cfg_data_i;
          cspi_pkg::CFG_SPEED_KI:   ski_q      <= cfg_data_i[14:0];
          cspi_pkg::CFG_CUR_KP:     ckp_q      <= cfg_data_i[14:0];
          cspi_pkg::CFG_CUR_KI:     cki_q      <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      spd_int_q   <= spd_int_d;
      cur_int_q   <= cur_int_d;
      spd_out_q   <= spd_out_d;
      spd_unsat_q <= spd_unsat_d;
      cur_unsat_q <= cur_unsat_d;
      cnt_q       <= cnt_d;
      drive_q     <= drive_d;
      sclamp_q    <= sclamp_d;
      dclamp_q    <= dclamp_d;
      supd_q      <= supd_d;
    end
  end

  // Payload registers: inputs, product, gain, result
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      tgt_q  <= target_rpm_i;
      mrpm_q <= measured_rpm_i;
      mcur_q <= measured_current_i;
      clr_q  <= clear_i;
    end
    prod_q <= mul_p[31:0];
    if (cmd_i.sched) begin
      kp_q <= kp_sched;
    end
    if (cmd_i.out_load) begin
      current_ref_o   <= spd_out_q;
      drive_o         <= drive_q;
      speed_clamped_o <= sclamp_q;
      drive_clamped_o <= dclamp_q;
      speed_updated_o <= supd_q;
    end
  end

  `CSPI_ASSERT(a_ref_in_limit, (spd_out_q <= cspi_pkg::CUR_LIM_POS) && (spd_out_q >= cspi_pkg::CUR_LIM_NEG), "current reference beyond limit")
  `CSPI_ASSERT(a_sclamp_needs_update, sclamp_q |-> supd_q, "speed clamp flag without speed update")
  `CSPI_ASSERT(a_divider_range, cnt_q < cspi_pkg::SPD_DIV, "speed divider out of range")

endmodule

// ===== hw/rtl/cascaded_speed_current_pi_top.sv =====
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    target_rpm, measured_rpm, measured_current, clear
// out       output     out_valid_o / out_ready_i  current_ref, drive, speed/drive clamp, speed_updated
// cfg       input      cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// A tick runs from input transfer through a check, the current-loop steps and an output step;
// a speed-loop tick also runs the schedule and speed steps. One shared 18 x 26 multiplier
// gives one product per step. A clear tick skips to the output step. Reset zeroes the gains,
// integrals, flags and divider. The result sits in an output register: the next tick is taken
// while it waits, and that tick holds in its final step until the pending result is transferred.

module cascaded_speed_current_pi_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [15:0]              target_rpm_i,
  input  logic signed [15:0]              measured_rpm_i,
  input  logic signed [15:0]              measured_current_i,
  input  logic                            clear_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [15:0]              current_ref_o,
  output logic [14:0]                     drive_o,
  output logic                            speed_clamped_o,
  output logic                            drive_clamped_o,
  output logic                            speed_updated_o,
  input  logic                            cfg_we_i,
  input  logic [cspi_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cspi_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  cspi_pkg::cmd_t cmd;
  cspi_pkg::sts_t sts;

  // Step sequencer
  cspi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Loop arithmetic and state
  cspi_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .target_rpm_i       (target_rpm_i),
    .measured_rpm_i     (measured_rpm_i),
    .measured_current_i (measured_current_i),
    .clear_i            (clear_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .current_ref_o      (current_ref_o),
    .drive_o            (drive_o),
    .speed_clamped_o    (speed_clamped_o),
    .drive_clamped_o    (drive_clamped_o),
    .speed_updated_o    (speed_updated_o)
  );

endmodule

// ===== tb/cascaded_speed_current_pi_top_tb.sv =====
`timescale 1ns / 100ps

module cascaded_speed_current_pi_top_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_TICKS = 144;
  localparam int NUM_PHASES  = 8;

  // One control tick in, one controller output back
  typedef struct packed {
    logic [15:0] target;
    logic [15:0] meas_rpm;
    logic [15:0] meas_cur;
    logic        clear;
  } tick_t;

  typedef struct packed {
    logic [15:0] current_ref;
    logic [14:0] drive;
    logic        speed_clamped;
    logic        drive_clamped;
    logic        speed_updated;
  } ctl_out_t;

  typedef enum int {GAINS_DIRECTED, GAINS_TYPICAL, GAINS_MAX, GAINS_MIN, GAINS_RANDOM} gains_e;
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  // DUT signals
  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic signed [15:0]              target_rpm_i = '0;
  logic signed [15:0]              measured_rpm_i = '0;
  logic signed [15:0]              measured_current_i = '0;
  logic                            clear_i = 1'b0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic signed [15:0]              current_ref_o;
  logic [14:0]                     drive_o;
  logic                            speed_clamped_o;
  logic                            drive_clamped_o;
  logic                            speed_updated_o;
  logic                            cfg_we_i = 1'b0;
  logic [cspi_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [cspi_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  // Controller model: gains and loop state
  logic [15:0] hi_shelf = '0;
  logic [15:0] lo_shelf = '0;
  logic [31:0] kp_high_g = '0;
  logic [31:0] kp_low_g = '0;
  logic [31:0] slope_g = '0;
  logic [31:0] ski_g = '0;
  logic [31:0] ckp_g = '0;
  logic [31:0] cki_g = '0;
  logic [31:0] spd_integ = '0;
  logic [31:0] cur_integ = '0;
  logic [15:0] spd_out = '0;
  logic        spd_unsat = 1'b0;
  logic        cur_unsat = 1'b0;
  logic [15:0] div_cnt = '0;

  // Testbench bookkeeping
  tick_t    tick_q[$];
  ctl_out_t ctl_expect_q[$];
  tick_t    offered = '0;
  tick_t    next_tick;
  ctl_out_t want;
  logic     in_fire;
  logic     hold_off = 1'b0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       fault_cnt = 0;
  int       cycle_cnt = 0;
  gains_e   phase_gains[NUM_PHASES] = '{GAINS_TYPICAL, GAINS_MAX, GAINS_TYPICAL, GAINS_MIN,
                                        GAINS_RANDOM, GAINS_TYPICAL, GAINS_RANDOM, GAINS_MAX};

  cascaded_speed_current_pi_top dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int sx(logic [15:0] v);
    return int'($signed(v));
  endfunction

  // Scheduled-gain speed PI every SPEED_DIVIDE ticks, current PI every non-clear tick
  function automatic ctl_out_t control_tick(tick_t t);
    ctl_out_t           r;
    logic [31:0]        gain;
    logic [31:0]        err;
    logic [31:0]        acc;
    logic [63:0]        wide;
    logic signed [15:0] spd_sig;
    logic signed [31:0] drv_sig;
    r = '0;
    if (t.clear) begin
      spd_integ = '0;
      cur_integ = '0;
      spd_out = '0;
      div_cnt = '0;
      return r;
    end
    div_cnt = div_cnt + 16'd1;
    if (div_cnt >= cspi_pkg::SPD_DIV) begin
      // gain schedule between the two shelves
      if (sx(t.target) > sx(hi_shelf)) begin
        gain = kp_high_g;
      end else if (sx(t.target) > sx(lo_shelf)) begin
        wide = 64'(32'(sx(hi_shelf) - sx(t.target))) * 64'(slope_g);
        gain = 32'(wide >> cspi_pkg::SCHED_SHIFT) + kp_high_g;
      end else begin
        gain = kp_low_g;
      end
      err = 32'(sx(t.target) - sx(t.meas_rpm));
      if (spd_unsat) spd_integ = spd_integ + err * ski_g;
      acc = err * gain + spd_integ;
      spd_sig = 16'($signed(acc) >>> cspi_pkg::SPEED_SHIFT);
      if (spd_sig > cspi_pkg::CURRENT_LIMIT) begin
        spd_out = cspi_pkg::CUR_LIM_POS;
        spd_unsat = 1'b0;
        r.speed_clamped = 1'b1;
      end else if (spd_sig < -cspi_pkg::CURRENT_LIMIT) begin
        spd_out = cspi_pkg::CUR_LIM_NEG;
        spd_unsat = 1'b0;
        r.speed_clamped = 1'b1;
      end else begin
        spd_out = spd_sig;
        spd_unsat = 1'b1;
      end
      div_cnt = '0;
      r.speed_updated = 1'b1;
    end
    // current loop against the held reference
    err = 32'(sx(spd_out) - sx(t.meas_cur));
    if (sx(t.target) == 0) cur_integ = '0;
    if (cur_unsat) cur_integ = cur_integ + err * cki_g;
    acc = err * ckp_g + cur_integ;
    drv_sig = $signed(acc) >>> cspi_pkg::CURRENT_SHIFT;
    if (drv_sig > cspi_pkg::DRIVE_MAX) begin
      r.drive = 15'(cspi_pkg::DRIVE_MAX);
      cur_unsat = 1'b0;
      r.drive_clamped = 1'b1;
    end else if (drv_sig < 0) begin
      r.drive = '0;
      cur_unsat = 1'b0;
      r.drive_clamped = 1'b1;
    end else begin
      r.drive = drv_sig[14:0];
      cur_unsat = 1'b1;
    end
    r.current_ref = spd_out;
    return r;
  endfunction

  // Mostly near-steady-state ticks, some zero targets, clears and wild values
  function automatic tick_t random_tick();
    tick_t t;
    int    sel;
    int    tg;
    sel = $urandom_range(99);
    t.target = 16'($urandom);
    t.meas_rpm = 16'($urandom);
    t.meas_cur = 16'($urandom);
    t.clear = 1'b0;
    if (sel < 4) begin
      t.clear = 1'b1;
    end else if (sel < 12) begin
      t.target = '0;
      t.meas_rpm = 16'(int'($urandom_range(600)) - 300);
      t.meas_cur = 16'(int'($urandom_range(2000)) - 1000);
    end else if (sel < 84) begin
      tg = int'($urandom_range(7000)) - 3500;
      t.target = 16'(tg);
      t.meas_rpm = 16'(tg + int'($urandom_range(400)) - 200);
      t.meas_cur = 16'(int'($urandom_range(9000)) - 4500);
    end
    return t;
  endfunction

  task automatic compare_field(string fname, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", fname, exp_val, act_val);
      fault_cnt++;
    end
  endtask

  task automatic queue_tick(int tg, int mr, int mc, logic clr);
    tick_q.push_back(tick_t'{16'(tg), 16'(mr), 16'(mc), clr});
  endtask

  // Checked on the falling edge, once the rising-edge updates have settled
  task automatic wait_drained();
    @(negedge clk_i);
    while (tick_q.size() != 0 || in_valid_i || ctl_expect_q.size() != 0) @(negedge clk_i);
  endtask

  // One register write per clock; the model copy is safe to update since the block is idle
  task automatic write_reg(cspi_pkg::cfg_reg_e idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      cspi_pkg::CFG_HIGH_SHELF: hi_shelf = data;
      cspi_pkg::CFG_LOW_SHELF:  lo_shelf = data;
      cspi_pkg::CFG_SKP_HIGH:   kp_high_g = 32'(data[14:0]);
      cspi_pkg::CFG_SKP_LOW:    kp_low_g = 32'(data[14:0]);
      cspi_pkg::CFG_SLOPE:      slope_g = 32'(data);
      cspi_pkg::CFG_SPEED_KI:   ski_g = 32'(data[14:0]);
      cspi_pkg::CFG_CUR_KP:     ckp_g = 32'(data[14:0]);
      cspi_pkg::CFG_CUR_KI:     cki_g = 32'(data[14:0]);
      default: ;
    endcase
  endtask

  task automatic load_gains(gains_e kind);
    logic [15:0] hi, lo, kph, kpl, slope, ski, ckp, cki;
    int          v;
    case (kind)
      GAINS_DIRECTED: begin
        hi = 16'd1000; lo = 16'(-1000); kph = 16'd3000; kpl = 16'd6000;
        slope = 16'd512; ski = 16'd40; ckp = 16'd4096; cki = 16'd80;
      end
      GAINS_TYPICAL: begin
        v = $urandom_range(2000);
        hi = 16'($urandom_range(3000, 500)); lo = 16'(-v);
        kph = 16'($urandom_range(6000, 1024)); kpl = 16'($urandom_range(12000, 2000));
        slope = 16'($urandom_range(1024)); ski = 16'($urandom_range(200));
        ckp = 16'($urandom_range(12000, 1024)); cki = 16'($urandom_range(400));
      end
      // widest shelves, full gains; bit 15 set on the 15-bit registers
      GAINS_MAX: begin
        hi = 16'h7fff; lo = 16'h8000; kph = 16'hffff; kpl = 16'hffff;
        slope = 16'hffff; ski = 16'hffff; ckp = 16'hffff; cki = 16'hffff;
      end
      // inverted shelves, gains that mask down to zero
      GAINS_MIN: begin
        hi = 16'h8000; lo = 16'h7fff; kph = 16'h8000; kpl = 16'h8000;
        slope = 16'h0000; ski = 16'h8000; ckp = 16'h8000; cki = 16'h8000;
      end
      default: begin
        hi = 16'($urandom); lo = 16'($urandom); kph = 16'($urandom); kpl = 16'($urandom);
        slope = 16'($urandom); ski = 16'($urandom); ckp = 16'($urandom); cki = 16'($urandom);
      end
    endcase
    write_reg(cspi_pkg::CFG_HIGH_SHELF, hi);
    write_reg(cspi_pkg::CFG_LOW_SHELF, lo);
    write_reg(cspi_pkg::CFG_SKP_HIGH, kph);
    write_reg(cspi_pkg::CFG_SKP_LOW, kpl);
    write_reg(cspi_pkg::CFG_SLOPE, slope);
    write_reg(cspi_pkg::CFG_SPEED_KI, ski);
    write_reg(cspi_pkg::CFG_CUR_KP, ckp);
    write_reg(cspi_pkg::CFG_CUR_KI, cki);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idling(idle_e mode);
    case (mode)
      IDLE_SEND: begin send_idle_pct = 67; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 67; end
      IDLE_BOTH: begin send_idle_pct = 36; recv_stall_pct = 36; end
      default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // Input driver: predict on each transfer, then offer the next tick or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      in_fire = in_valid_i && in_ready_o;
      if (in_fire) ctl_expect_q.push_back(control_tick(offered));
      if (!in_valid_i || in_fire) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_tick = tick_q.pop_front();
          in_valid_i <= 1'b1;
          offered <= next_tick;
          target_rpm_i <= next_tick.target;
          measured_rpm_i <= next_tick.meas_rpm;
          measured_current_i <= next_tick.meas_cur;
          clear_i <= next_tick.clear;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each transfer against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (ctl_expect_q.size() == 0) begin
          $error("unexpected result: current_ref %0d drive %0d", current_ref_o, drive_o);
          fault_cnt++;
        end else begin
          want = ctl_expect_q.pop_front();
          compare_field("current_ref", sx(want.current_ref), int'(current_ref_o));
          compare_field("drive", int'(want.drive), int'(drive_o));
          compare_field("speed_clamped", int'(want.speed_clamped), int'(speed_clamped_o));
          compare_field("drive_clamped", int'(want.drive_clamped), int'(drive_clamped_o));
          compare_field("speed_updated", int'(want.speed_updated), int'(speed_updated_o));
        end
      end
      out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("cascaded_speed_current_pi_top_tb: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset gains: everything zero
    queue_tick(100, 50, 10, 1'b0);
    queue_tick(0, 0, 0, 1'b0);
    queue_tick(-32768, 32767, -32768, 1'b0);
    wait_drained();

    // directed: shelves, extremes, zero target, clears, two speed updates
    load_gains(GAINS_DIRECTED);
    queue_tick(0, 0, 0, 1'b1);
    queue_tick(2000, 1900, 0, 1'b0);
    queue_tick(1000, 1000, 100, 1'b0);
    queue_tick(0, 0, 0, 1'b0);
    queue_tick(-1000, -900, -50, 1'b0);
    queue_tick(32767, -32768, -32768, 1'b0);
    queue_tick(-32768, 32767, 32767, 1'b0);
    queue_tick(500, 400, 0, 1'b0);
    queue_tick(500, 450, 0, 1'b0);
    queue_tick(500, 480, 200, 1'b0);
    queue_tick(2000, 0, 0, 1'b0);
    queue_tick(1000, 900, 4096, 1'b0);
    queue_tick(1000, 950, 4000, 1'b0);
    queue_tick(-500, -600, 0, 1'b0);
    queue_tick(-32768, -32768, 0, 1'b0);
    queue_tick(32767, 32767, -32768, 1'b0);
    queue_tick(0, 100, 0, 1'b0);
    queue_tick(300, 250, 0, 1'b0);
    queue_tick(300, 290, 0, 1'b0);
    queue_tick(-2000, 2000, 0, 1'b0);
    queue_tick(1000, 990, 0, 1'b0);
    queue_tick(-1, -1, -1, 1'b1);
    wait_drained();

    // random phases, each with its own gains and idling pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      load_gains(phase_gains[p]);
      set_idling(idle_e'(p % 4));
      for (int n = 0; n < PHASE_TICKS; n++) tick_q.push_back(random_tick());
      if (p == 0) begin
        // long output stall while ticks keep coming: block must back up
        @(posedge clk_i);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (fault_cnt == 0) begin
      $display("cascaded_speed_current_pi_top_tb: done, clean");
    end else begin
      $display("cascaded_speed_current_pi_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== cascaded_speed_current_pi_top.f =====
+incdir+hw/rtl
hw/rtl/cspi_pkg.sv
hw/rtl/cspi_ctrl.sv
hw/rtl/cspi_dp.sv
hw/rtl/cascaded_speed_current_pi_top.sv
tb/cascaded_speed_current_pi_top_tb.sv
